>>> rtl/assert_macros.svh
// Assertion macros used by the checker file ssg_checker.sv.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/ssg_pkg.sv
// Types, constants and helper functions of the spectral subtraction gain block.
// No dependencies; imported by spectral_subtraction_gain.
package ssg_pkg;

  localparam int FFT_SIZE  = 2048;
  localparam int CHANNELS  = 2;
  localparam int NBINS     = FFT_SIZE / 2 + 1;
  localparam int MEM_DEPTH = CHANNELS * NBINS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int NP_W      = 48;

  localparam logic [16:0] UNITY       = 17'd65536;
  localparam logic [15:0] ALPHA_RST   = 16'd24576;
  localparam logic [12:0] FLOOR_RST   = 13'd3277;
  localparam logic [15:0] ATTACK_RST  = 16'd4096;
  localparam logic [15:0] RELEASE_RST = 16'd512;

  typedef enum logic [1:0] {
    CFG_OVER_SUB = 2'd0,
    CFG_FLOOR    = 2'd1,
    CFG_ATTACK   = 2'd2,
    CFG_RELEASE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               vld;
    logic               byp;
    logic               edg;
    logic signed [23:0] re;
    logic signed [23:0] im;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic        zero;
    logic [66:0] rem;
    logic [47:0] den;
    logic [15:0] q;
  } div_t;

  typedef struct packed {
    item_t       it;
    logic [32:0] x;
    logic [33:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [16:0]        mg;
  } res_t;

  function automatic logic [23:0] mag24(logic [23:0] v);
    logic [23:0] m;
    m = v[23] ? (~v + 24'd1) : v;
    return m;
  endfunction

endpackage

>>> rtl/ssg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssg_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/spectral_subtraction_gain.sv
// Spectral subtraction gain: one request per cycle while the skid register is empty;
// the rate is limited by the noise estimate RAM read-modify-write.
// A request whose estimate entry is still being updated by one of the four requests
// ahead of it waits until that write is done.
// Reset is asynchronous, active low; afterwards a clearing pass writes every estimate
// entry, and no request is accepted meanwhile.
module spectral_subtraction_gain import ssg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               chan_i,
  input  logic [10:0]        bin_index_i,
  input  logic signed [23:0] bin_real_i,
  input  logic signed [23:0] bin_imag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] out_real_o,
  output logic signed [23:0] out_imag_o,
  output logic [16:0]        mag_gain_o
);

  logic [15:0] alpha_q, attack_q, release_q;
  logic [12:0] floor_q;
  logic              clr_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic              adv, in_fire, hazard, in_range, in_edge;
  logic [ADDR_W-1:0] in_addr;
  item_t             in_item;

  item_t             a_q, b_q, c_q, d_q, e_q, f_q, s_q;
  logic [ADDR_W-1:0] a_addr_q, b_addr_q, c_addr_q, d_addr_q;
  logic [NP_W-1:0]   ram_rdata, ram_wdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_we;

  logic [23:0]       a_mr, a_mi;
  logic [NP_W-1:0]   b_n_q, b_rr_q, b_ii_q;
  logic [NP_W-1:0]   b_p;
  logic [NP_W-1:0]   c_p_q, c_n_q, c_diff_q;
  logic              c_lt_q;
  logic [15:0]       c_coef;
  logic [63:0]       c_prod;
  logic [NP_W-1:0]   d_p_q, d_n_q, d_inc_q, d_nnew;
  logic              d_lt_q;
  logic [NP_W-1:0]   e_n_q, e_p_q;
  logic [63:0]       f_num_q;
  logic [NP_W-1:0]   f_den_q;

  div_t              dv_q [17];
  sq_t               sq_q [18];
  logic [16:0]       h_g;
  logic [16:0]       sq_mg;
  logic [40:0]       s_pr_q, s_pi_q;
  logic              s_nr_q, s_ni_q;
  logic [16:0]       s_mg_q;
  logic [41:0]       s_rr, s_ri;
  logic [23:0]       s_r, s_i;
  res_t              s_res, out_q, skid_q;
  logic              out_vld_q, skid_vld_q, arr, out_take;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RST;
      floor_q   <= FLOOR_RST;
      attack_q  <= ATTACK_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OVER_SUB: alpha_q   <= cfg_wdata_i;
        CFG_FLOOR:    floor_q   <= cfg_wdata_i[12:0];
        CFG_ATTACK:   attack_q  <= cfg_wdata_i;
        CFG_RELEASE:  release_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // input side
  assign in_range = (32'(chan_i) < CHANNELS) && (32'(bin_index_i) < NBINS);
  assign in_edge  = (bin_index_i == 11'd0) || (32'(bin_index_i) == FFT_SIZE / 2);
  assign in_addr  = ADDR_W'(ADDR_W'(chan_i) * ADDR_W'(NBINS) + ADDR_W'(bin_index_i));

  assign hazard = in_range && (
      (a_q.vld && !a_q.byp && a_addr_q == in_addr) ||
      (b_q.vld && !b_q.byp && b_addr_q == in_addr) ||
      (c_q.vld && !c_q.byp && c_addr_q == in_addr) ||
      (d_q.vld && !d_q.byp && d_addr_q == in_addr));

  assign adv        = !skid_vld_q;
  assign in_ready_o = adv && !clr_q && !hazard;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_item.vld = in_fire;
    in_item.byp = !in_range;
    in_item.edg = in_edge;
    in_item.re  = bin_real_i;
    in_item.im  = bin_imag_i;
  end

  ssg_ram #(.W(NP_W), .DEPTH(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // front stages: read, power, difference, step, update
  assign a_mr   = mag24(a_q.re);
  assign a_mi   = mag24(a_q.im);
  assign b_p    = b_rr_q + b_ii_q;
  assign c_coef = c_lt_q ? attack_q : release_q;
  assign c_prod = 64'(c_diff_q) * 64'(c_coef);

  always_comb begin
    d_nnew = d_lt_q ? (d_n_q - d_inc_q) : (d_n_q + d_inc_q);
    if (d_nnew == '0) begin
      d_nnew = NP_W'(1);
    end
  end

  assign ram_we    = clr_q || (adv && d_q.vld && !d_q.byp);
  assign ram_waddr = clr_q ? clr_cnt_q : d_addr_q;
  assign ram_wdata = clr_q ? NP_W'(1) : d_nnew;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; f_q <= '0;
    end else if (adv) begin
      a_q <= in_item;
      b_q <= a_q;
      c_q <= b_q;
      d_q <= c_q;
      e_q <= d_q;
      f_q <= e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_addr_q <= in_addr;
      b_addr_q <= a_addr_q;
      b_n_q    <= ram_rdata;
      b_rr_q   <= NP_W'(a_mr) * NP_W'(a_mr);
      b_ii_q   <= a_q.edg ? '0 : NP_W'(a_mi) * NP_W'(a_mi);
      c_addr_q <= b_addr_q;
      c_p_q    <= b_p;
      c_n_q    <= b_n_q;
      c_lt_q   <= b_p < b_n_q;
      c_diff_q <= (b_p < b_n_q) ? (b_n_q - b_p) : (b_p - b_n_q);
      d_addr_q <= c_addr_q;
      d_p_q    <= c_p_q;
      d_n_q    <= c_n_q;
      d_lt_q   <= c_lt_q;
      d_inc_q  <= c_prod[63:16];
      e_n_q    <= d_nnew;
      e_p_q    <= d_p_q;
      f_num_q  <= 64'(alpha_q) * 64'(e_n_q);
      f_den_q  <= (e_p_q == '0) ? NP_W'(1) : e_p_q;
    end
  end

  // quotient alpha*N*8/D, one bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (adv) begin
      dv_q[0].it   <= f_q;
      dv_q[0].zero <= f_num_q >= (64'(f_den_q) << 13);
      dv_q[0].rem  <= {f_num_q, 3'b000};
      dv_q[0].den  <= f_den_q;
      dv_q[0].q    <= '0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_div
    logic [66:0] dsh;
    div_t        dv_d;
    assign dsh = 67'(dv_q[k].den) << (15 - k);
    always_comb begin
      dv_d = dv_q[k];
      if (dv_q[k].rem >= dsh) begin
        dv_d.rem       = dv_q[k].rem - dsh;
        dv_d.q[15 - k] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= '0;
      end else if (adv) begin
        dv_q[k+1] <= dv_d;
      end
    end
  end

  // power gain with floor, then square root one bit per stage
  always_comb begin
    h_g = dv_q[16].zero ? 17'd0 : (UNITY - 17'(dv_q[16].q));
    if (h_g < 17'(floor_q)) begin
      h_g = 17'(floor_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (adv) begin
      sq_q[0].it <= dv_q[16].it;
      sq_q[0].x  <= {h_g, 16'h0000};
      sq_q[0].r  <= '0;
    end
  end

  for (genvar k = 0; k < 17; k++) begin : g_sqrt
    logic [33:0] sbit, trial;
    assign sbit  = 34'(1) << (2 * (16 - k));
    assign trial = sq_q[k].r + sbit;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (adv) begin
        sq_q[k+1].it <= sq_q[k].it;
        if (34'(sq_q[k].x) >= trial) begin
          sq_q[k+1].x <= 33'(34'(sq_q[k].x) - trial);
          sq_q[k+1].r <= (sq_q[k].r >> 1) + sbit;
        end else begin
          sq_q[k+1].x <= sq_q[k].x;
          sq_q[k+1].r <= sq_q[k].r >> 1;
        end
      end
    end
  end

  assign sq_mg = (sq_q[17].r > 34'(UNITY)) ? UNITY : sq_q[17].r[16:0];

  // scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (adv) begin
      s_q <= sq_q[17].it;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_pr_q <= 41'(mag24(sq_q[17].it.re)) * 41'(sq_mg);
      s_pi_q <= 41'(mag24(sq_q[17].it.im)) * 41'(sq_mg);
      s_nr_q <= sq_q[17].it.re[23];
      s_ni_q <= sq_q[17].it.im[23];
      s_mg_q <= sq_mg;
    end
  end

  assign s_rr = 42'(s_pr_q) + 42'd32768;
  assign s_ri = 42'(s_pi_q) + 42'd32768;
  assign s_r  = s_nr_q ? (~s_rr[39:16] + 24'd1) : s_rr[39:16];
  assign s_i  = s_ni_q ? (~s_ri[39:16] + 24'd1) : s_ri[39:16];

  always_comb begin
    s_res.re = s_q.byp ? s_q.re : s_r;
    s_res.im = (s_q.byp || s_q.edg) ? s_q.im : s_i;
    s_res.mg = s_q.byp ? UNITY : s_mg_q;
  end

  // output register and skid
  assign arr      = adv && s_q.vld;
  assign out_take = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (arr) begin
      if (out_vld_q && !out_take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (arr) begin
      if (out_vld_q && !out_take) begin
        skid_q <= s_res;
      end else begin
        out_q <= s_res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_real_o  = out_q.re;
  assign out_imag_o  = out_q.im;
  assign mag_gain_o  = out_q.mg;

endmodule

>>> rtl/ssg_checker.sv
// Port-level checker for the spectral subtraction gain block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [1:0]         cfg_index_i,
  input logic [15:0]        cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               chan_i,
  input logic [10:0]        bin_index_i,
  input logic signed [23:0] bin_real_i,
  input logic signed [23:0] bin_imag_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [23:0] out_real_o,
  input logic signed [23:0] out_imag_o,
  input logic [16:0]        mag_gain_o
);

  `SSG_ASSERT(a_clear_blocks, (rst_ni && !$past(rst_ni)) |-> !in_ready_o, "request taken during clearing")
  `SSG_ASSERT_ALWAYS(a_gain_bound, out_valid_o |-> (mag_gain_o <= 17'd65536), "gain above unity")
  `SSG_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_real_o) && $stable(out_imag_o) && $stable(mag_gain_o)), "result dropped or changed")
  `SSG_ASSERT(a_no_early_result, (rst_ni && !$past(rst_ni)) |-> !out_valid_o, "result without request")

endmodule

bind spectral_subtraction_gain ssg_checker u_ssg_checker (.*);
